/* design/swm_pkg.sv */
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants for the sliding window median block
// Sample, result and configuration types, and the control word that the
// top level broadcasts to every cell of the sorted chain.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int SAMPLE_W = 32;
    localparam int MEDIAN_W = 33;
    localparam int CFG_W    = 7;
    // window size after reset
    localparam int WS_RESET = 3;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [MEDIAN_W-1:0] t_median;
    typedef logic [CFG_W-1:0]           t_cfg;

    // broadcast to every cell for one accepted word
    typedef struct packed {
        logic    load;       // update the chain this cycle
        logic    evict;      // window full: drop one copy of evict_val first
        t_sample sample;     // value to insert
        t_sample evict_val;  // oldest value of the window
    } t_cell_ctrl;

endpackage

/* design/swm_cell.sv */
// ----------------------------------------------------------------------------
// swm_cell: one slot of the sorted window chain
// Holds one ordered sample. An update on a full window removes the oldest value from the
// chain (cells at or above it pull from the right) and inserts the new
// sample (cells above it pull from the left), using only neighbour data.
// ----------------------------------------------------------------------------
module swm_cell #(
    parameter int INDEX = 0,
    parameter int KW    = 7
) (
    input  logic                i_clk,
    input  swm_pkg::t_cell_ctrl i_ctrl,
    input  logic [KW-1:0]       i_count,
    input  logic [KW-1:0]       i_mid_lo,
    input  logic [KW-1:0]       i_mid_hi,
    input  swm_pkg::t_sample    i_next_val,
    input  logic                i_next_lt,
    input  swm_pkg::t_sample    i_prev_rem,
    input  logic                i_prev_lt_rem,
    output swm_pkg::t_sample    o_val,
    output logic                o_lt,
    output swm_pkg::t_sample    o_rem,
    output logic                o_lt_rem,
    output swm_pkg::t_sample    o_tap_lo,
    output swm_pkg::t_sample    o_tap_hi
);

    swm_pkg::t_sample r_val;
    swm_pkg::t_sample r_tap_lo;
    swm_pkg::t_sample r_tap_hi;
    swm_pkg::t_sample n_val;
    logic             held;
    logic             ge_evict;

    // compare against the new sample and the value being evicted
    always_comb begin
        held     = KW'(INDEX) < i_count;
        o_lt     = held && (r_val < i_ctrl.sample);
        ge_evict = i_ctrl.evict && (r_val >= i_ctrl.evict_val);
        // after removal: slots from the evicted one upwards take the right neighbour
        o_rem    = ge_evict ? i_next_val : r_val;
        o_lt_rem = ge_evict ? i_next_lt : o_lt;
        // after insertion: keep smaller, take the sample at the gap, else shift up
        if (o_lt_rem) begin
            n_val = o_rem;
        end else if (i_prev_lt_rem) begin
            n_val = i_ctrl.sample;
        end else begin
            n_val = i_prev_rem;
        end
    end

    // advance the slot and latch the median taps
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_val    <= n_val;
            r_tap_lo <= (KW'(INDEX) == i_mid_lo) ? n_val : '0;
            r_tap_hi <= (KW'(INDEX) == i_mid_hi) ? n_val : '0;
        end
    end

    assign o_val    = r_val;
    assign o_tap_lo = r_tap_lo;
    assign o_tap_hi = r_tap_hi;

endmodule

/* design/sliding_window_median.sv */
// ----------------------------------------------------------------------------
// sliding_window_median: running median over a sliding window of samples
// Sorted chain of cells plus an arrival-order history memory.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_ready carry one word (i_sample, i_restart).
// i_restart empties the window before the sample is taken. Output channel:
// o_out_valid / i_out_ready carry o_median_x2, twice the window median,
// emitted for every word once the window holds window_size samples.
// Configuration: i_window_size_we writes i_window_size (0 acts as 1, values
// above WINDOW_MAX saturate) and empties the window; write only while idle.
// Throughput: one word per cycle while o_in_ready is high. The chain of cells
// updates all slots together on acceptance; the evicted value is prefetched
// from the history memory into a register, so back-to-back words never wait
// on the memory read port. Pipeline: the cell update latches the median taps,
// then the tap reduction and add go into the output register.
// Stall: a held result and one result in the tap stage are kept; o_in_ready
// drops only while both are full and i_out_ready is low.
// Reset: window empty, window_size 3, nothing pending; no clearing pass.
// ----------------------------------------------------------------------------
module sliding_window_median #(
    parameter int WINDOW_MAX = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  swm_pkg::t_sample i_sample,
    input  logic             i_restart,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output swm_pkg::t_median o_median_x2,
    input  logic             i_window_size_we,
    input  swm_pkg::t_cfg    i_window_size
);

    localparam int KW      = $clog2(WINDOW_MAX + 1);
    localparam int PW      = $clog2(WINDOW_MAX);
    localparam int K_RESET = (swm_pkg::WS_RESET > WINDOW_MAX) ? WINDOW_MAX
                                                               : swm_pkg::WS_RESET;

    // control registers
    logic [KW-1:0]       r_k;
    logic [KW-1:0]       r_fill;
    logic [PW-1:0]       r_ptr;
    logic                r_tap_valid;
    logic                r_out_valid;
    logic [KW-1:0]       n_fill;
    logic [PW-1:0]       n_ptr;
    // payload registers
    swm_pkg::t_sample    r_hist [WINDOW_MAX];
    swm_pkg::t_sample    r_evict;
    swm_pkg::t_median    r_median;

    logic [31:0]         ws_ext;
    logic [KW-1:0]       k_cfg;
    logic                accept;
    logic [KW-1:0]       count_eff;
    logic                full;
    logic [KW-1:0]       fill_next;
    logic [PW-1:0]       wr_addr;
    logic [KW-1:0]       ptr_inc;
    logic [PW-1:0]       ptr_wrap;
    logic [KW-1:0]       mid_lo;
    logic [KW-1:0]       mid_hi;
    logic                tap_move;
    swm_pkg::t_cell_ctrl ctrl;
    swm_pkg::t_sample    red_lo;
    swm_pkg::t_sample    red_hi;
    swm_pkg::t_median    sum;

    swm_pkg::t_sample    cell_val    [WINDOW_MAX];
    logic                cell_lt     [WINDOW_MAX];
    swm_pkg::t_sample    cell_rem    [WINDOW_MAX];
    logic                cell_lt_rem [WINDOW_MAX];
    swm_pkg::t_sample    tap_lo      [WINDOW_MAX];
    swm_pkg::t_sample    tap_hi      [WINDOW_MAX];
    swm_pkg::t_sample    nxt_val     [WINDOW_MAX];
    logic                nxt_lt      [WINDOW_MAX];
    swm_pkg::t_sample    prv_rem     [WINDOW_MAX];
    logic                prv_lt      [WINDOW_MAX];

    // clamp the written window size to 1..WINDOW_MAX
    always_comb begin
        ws_ext = 32'(i_window_size);
        if (ws_ext == 32'd0) begin
            k_cfg = KW'(1);
        end else if (ws_ext > 32'(WINDOW_MAX)) begin
            k_cfg = KW'(WINDOW_MAX);
        end else begin
            k_cfg = KW'(ws_ext);
        end
    end

    assign o_in_ready = !r_tap_valid || !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign tap_move   = r_tap_valid && (!r_out_valid || i_out_ready);

    // window bookkeeping for the word on the input
    always_comb begin
        count_eff = i_restart ? '0 : r_fill;
        full      = (count_eff == r_k);
        fill_next = full ? count_eff : count_eff + KW'(1);
        wr_addr   = full ? r_ptr : count_eff[PW-1:0];
        ptr_inc   = KW'(r_ptr) + KW'(1);
        if (!full) begin
            ptr_wrap = '0;
        end else if (ptr_inc == r_k) begin
            ptr_wrap = '0;
        end else begin
            ptr_wrap = ptr_inc[PW-1:0];
        end
        if (i_window_size_we) begin
            n_fill = '0;
            n_ptr  = '0;
        end else if (accept) begin
            n_fill = fill_next;
            n_ptr  = ptr_wrap;
        end else begin
            n_fill = r_fill;
            n_ptr  = r_ptr;
        end
        mid_lo = (r_k - KW'(1)) >> 1;
        mid_hi = r_k >> 1;
    end

    assign ctrl.load      = accept;
    assign ctrl.evict     = full;
    assign ctrl.sample    = i_sample;
    assign ctrl.evict_val = r_evict;

    // hold window size, fill count and ring pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k    <= KW'(K_RESET);
            r_fill <= '0;
            r_ptr  <= '0;
        end else begin
            if (i_window_size_we) begin
                r_k <= k_cfg;
            end
            r_fill <= n_fill;
            r_ptr  <= n_ptr;
        end
    end

    // write the arrival history and prefetch the next oldest sample
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hist[wr_addr] <= i_sample;
        end
        if (accept && (wr_addr == n_ptr)) begin
            r_evict <= i_sample;
        end else begin
            r_evict <= r_hist[n_ptr];
        end
    end

    // sorted chain of cells
    for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
        if (g == WINDOW_MAX - 1) begin : g_last
            assign nxt_val[g] = '0;
            assign nxt_lt[g]  = 1'b0;
        end else begin : g_mid
            assign nxt_val[g] = cell_val[g+1];
            assign nxt_lt[g]  = cell_lt[g+1];
        end
        if (g == 0) begin : g_first
            assign prv_rem[g] = '0;
            assign prv_lt[g]  = 1'b1;
        end else begin : g_rest
            assign prv_rem[g] = cell_rem[g-1];
            assign prv_lt[g]  = cell_lt_rem[g-1];
        end

        swm_cell #(
            .INDEX (g),
            .KW    (KW)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (ctrl),
            .i_count       (count_eff),
            .i_mid_lo      (mid_lo),
            .i_mid_hi      (mid_hi),
            .i_next_val    (nxt_val[g]),
            .i_next_lt     (nxt_lt[g]),
            .i_prev_rem    (prv_rem[g]),
            .i_prev_lt_rem (prv_lt[g]),
            .o_val         (cell_val[g]),
            .o_lt          (cell_lt[g]),
            .o_rem         (cell_rem[g]),
            .o_lt_rem      (cell_lt_rem[g]),
            .o_tap_lo      (tap_lo[g]),
            .o_tap_hi      (tap_hi[g])
        );
    end

    // gather the two middle taps and add them
    always_comb begin
        red_lo = '0;
        red_hi = '0;
        for (int j = 0; j < WINDOW_MAX; j++) begin
            red_lo = red_lo | tap_lo[j];
            red_hi = red_hi | tap_hi[j];
        end
        sum = {red_lo[swm_pkg::SAMPLE_W-1], red_lo} + {red_hi[swm_pkg::SAMPLE_W-1], red_hi};
    end

    // advance the tap stage and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_tap_valid <= (fill_next == r_k);
            end else if (tap_move) begin
                r_tap_valid <= 1'b0;
            end
            if (tap_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tap_move) begin
            r_median <= sum;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_median_x2 = r_median;

endmodule

/* design/swm_checker.sv */
// ----------------------------------------------------------------------------
// swm_checker: port-level checks for the sliding window median block
// Watches the handshakes on the top level and flags illegal sequences.
// ----------------------------------------------------------------------------
module swm_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_ready,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input swm_pkg::t_median o_median_x2
);

    // drop any pending result on reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word still valid after reset");

    // hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_median_x2))
        else $error("stalled result word changed or vanished");

    // a fresh result must be caused by an accepted input word
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready, 2))
        else $error("result word without an accepted input word");

    // back-pressure only while both result stages are full and stalled
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled without output back-pressure");

endmodule

bind sliding_window_median swm_checker u_swm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_median_x2 (o_median_x2)
);
